// ----- rtl/ile_pkg.sv -----
// shared types and constants for the indexed list engine
package ile_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int DATA_W           = 32;
  localparam int POS_W            = 8;
  localparam int CMD_W            = 3;
  localparam int STATUS_W         = 2;
  localparam int IN_W             = ((CMD_W + POS_W + DATA_W + 7) / 8) * 8;
  localparam int READ_GROUP       = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_POP_AT   = 3'd2,
    CMD_POP_LAST = 3'd3,
    CMD_GET      = 3'd4,
    CMD_SET      = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // per-cycle action broadcast to every cell
  typedef struct packed {
    logic load;  // cell at index takes the new value
    logic up;    // cells above index take their lower neighbor
    logic down;  // cells at and above index take their upper neighbor
    logic rd;    // cell at index drives its entry onto the read tree
  } cell_ctrl_t;

endpackage

// ----- rtl/ile_cell.sv -----
// one list entry cell of the shift chain
module ile_cell #(
  parameter int CMP_W = 9,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  ile_pkg::cell_ctrl_t       ctrl,
  input  logic [CMP_W-1:0]          idx,
  input  logic [ile_pkg::DATA_W-1:0] value,
  input  logic [ile_pkg::DATA_W-1:0] lower,
  input  logic [ile_pkg::DATA_W-1:0] upper,
  output logic [ile_pkg::DATA_W-1:0] entry,
  output logic [ile_pkg::DATA_W-1:0] rd_data
);
  import ile_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic hit;
  logic above;

  assign hit   = (idx == MY_IDX);
  assign above = (MY_IDX > idx);

  // entry update: load, shift up or shift down
  always_ff @(posedge clk) begin
    if (ctrl.load && hit) begin
      entry <= value;
    end else if (ctrl.up && above) begin
      entry <= lower;
    end else if (ctrl.down && (above || hit)) begin
      entry <= upper;
    end
  end

  // masked contribution to the read tree, taken before the shift
  assign rd_data = (ctrl.rd && hit) ? entry : '0;

endmodule

// ----- rtl/ile_read_tree.sv -----
// registered or-tree that collects the selected cell entry
module ile_read_tree #(
  parameter int N = 256
) (
  input  logic                       clk,
  input  logic                       capture,
  input  logic [ile_pkg::DATA_W-1:0] leaf [N],
  output logic [ile_pkg::DATA_W-1:0] result
);
  import ile_pkg::*;

  localparam int NGROUP = (N + READ_GROUP - 1) / READ_GROUP;

  logic [DATA_W-1:0] group_or [NGROUP];

  // first level: one register per group of cells
  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < NGROUP; g++) begin
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < READ_GROUP; j++) begin
          if (g * READ_GROUP + j < N) begin
            acc = acc | leaf[g * READ_GROUP + j];
          end
        end
        group_or[g] <= acc;
      end
    end
  end

  // second level: combine the group registers
  always_comb begin
    result = '0;
    for (int g = 0; g < NGROUP; g++) begin
      result = result | group_or[g];
    end
  end

endmodule

// ----- rtl/indexed_list_engine.sv -----
// top level of the indexed list engine: command decode, cell chain, result register
//
// A bounded ordered list of signed 32-bit entries used as a stack or a queue.
// The entries sit in a chain of CAPACITY cells; on each accepted command every
// cell loads, shifts up, shifts down or holds in the same clock, so insert and
// pop at any index change the list in the accepting cycle. A popped or read
// entry is gathered through a two-level registered or-tree over the cells,
// whose group registers feed the output register. One command is in flight
// at a time: a new command is accepted only when the in-flight stage is empty
// and any waiting output is being taken. No clearing pass follows reset; entries are read
// only below the count and are always written before that.
module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int OUT_W    = ((ile_pkg::DATA_W + ile_pkg::STATUS_W + CNT_W + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // command [2:0], position [10:3], value [42:11], zero pad
  input  logic [ile_pkg::IN_W-1:0] s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // read_value [31:0], status [33:32], count [33+CNT_W:34], zero pad
  output logic [OUT_W-1:0]        m_tdata
);
  import ile_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  // input fields
  logic [CMD_W-1:0]  cmd_raw;
  logic [POS_W-1:0]  pos_raw;
  logic [DATA_W-1:0] value;
  logic [CMP_W-1:0]  pos;
  logic [CMP_W-1:0]  n;

  assign cmd_raw = s_tdata[CMD_W-1:0];
  assign pos_raw = s_tdata[CMD_W +: POS_W];
  assign value   = s_tdata[CMD_W + POS_W +: DATA_W];
  assign pos     = CMP_W'(pos_raw);

  // state
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              p1_valid;
  logic [STATUS_W-1:0] p1_status;
  logic [CNT_W-1:0]  p1_count;
  logic              accept;

  assign n        = CMP_W'(count);
  assign s_tready = !rst && !p1_valid && !(m_tvalid && !m_tready);
  assign accept   = s_tvalid && s_tready;

  // command decode
  cell_ctrl_t        act;
  cell_ctrl_t        ctrl;
  logic [CMP_W-1:0]  idx;
  status_t           status;

  always_comb begin
    act        = '0;
    idx        = pos;
    status     = ST_OK;
    count_next = count;
    unique case (cmd_raw)
      CMD_APPEND: begin
        if (n >= CAP_C) begin
          status = ST_FULL;
        end else begin
          idx        = n;
          act.load   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (n >= CAP_C) begin
          status = ST_FULL;
        end else begin
          idx        = (pos > n) ? n : pos;
          act.load   = 1'b1;
          act.up     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_POP_AT, CMD_POP_LAST: begin
        if (n == '0) begin
          status = ST_EMPTY;
        end else begin
          idx = (cmd_raw == CMD_POP_LAST) ? n - 1'b1 : pos;
          if (idx >= n) begin
            status = ST_RANGE;
          end else begin
            act.rd     = 1'b1;
            act.down   = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      CMD_GET: begin
        if (pos >= n) begin
          status = ST_RANGE;
        end else begin
          act.rd = 1'b1;
        end
      end
      CMD_SET: begin
        if (pos >= n) begin
          status = ST_RANGE;
        end else begin
          act.load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl = accept ? act : '0;

  // cell chain
  logic [DATA_W-1:0] entry   [CAPACITY];
  logic [DATA_W-1:0] rd_leaf [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = entry[i+1];
    end
    ile_cell #(
      .CMP_W (CMP_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .idx     (idx),
      .value   (value),
      .lower   (lower),
      .upper   (upper),
      .entry   (entry[i]),
      .rd_data (rd_leaf[i])
    );
  end

  // read gather
  logic [DATA_W-1:0] rd_value;

  ile_read_tree #(
    .N (CAPACITY)
  ) u_read_tree (
    .clk     (clk),
    .capture (accept),
    .leaf    (rd_leaf),
    .result  (rd_value)
  );

  // count and in-flight stage
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      p1_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_status <= status;
      p1_count  <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p1_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      m_tdata <= OUT_W'({p1_count, p1_status, rd_value});
    end
  end

endmodule
